/* hdl/hbred_pkg.sv */
// ----------------------------------------------------------------------------
// hbred_pkg
// Shared types, constants and helpers of the boot report event decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbred_pkg;

    localparam int SLOT_MAX = 6;
    localparam int EV_COUNT = 16;
    localparam int EV_IDX_W = 4;

    localparam logic [7:0] USAGE_A_LO = 8'h04;
    localparam logic [7:0] USAGE_A_HI = 8'h2E;
    localparam logic [7:0] USAGE_B_LO = 8'h4F;
    localparam logic [7:0] USAGE_B_HI = 8'h52;

    localparam logic [3:0] LEN_MOUSE_SHORT = 4'd3;
    localparam logic [3:0] LEN_MOUSE       = 4'd4;

    // event slot layout inside one report
    localparam logic [EV_IDX_W-1:0] EV_REL_BASE  = 4'd4;
    localparam logic [EV_IDX_W-1:0] EV_PRS_BASE  = 4'd10;
    localparam logic [EV_IDX_W-1:0] EV_AXIS_BASE = 4'd3;

    typedef enum logic [1:0] {
        CLS_KEY    = 2'd0,
        CLS_MOD    = 2'd1,
        CLS_BUTTON = 2'd2,
        CLS_AXIS   = 2'd3
    } ev_class_t;

    typedef struct packed {
        logic                        is_kbd;
        logic [EV_COUNT-1:0]         mask;
        logic [3:0]                  bits;
        logic [SLOT_MAX-1:0][7:0]    old_keys;
        logic [SLOT_MAX-1:0][7:0]    new_keys;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    function automatic logic usage_mapped(input logic [7:0] u);
        return ((u >= USAGE_A_LO) && (u <= USAGE_A_HI)) ||
               ((u >= USAGE_B_LO) && (u <= USAGE_B_HI));
    endfunction

    // modifier order shift, ctrl, alt, meta: bit index equals code
    function automatic logic [1:0] mod_map(input logic [1:0] slot);
        logic [1:0] r;
        case (slot)
            2'd0: r = 2'd1;
            2'd1: r = 2'd0;
            default: r = slot;
        endcase
        return r;
    endfunction

endpackage

/* hdl/hbred_front.sv */
// ----------------------------------------------------------------------------
// hbred_front
// Accepts reports, classifies them and builds the pending event mask.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbred_front import hbred_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [3:0] s_report_len,
    input  logic [7:0] s_byte_0,
    input  logic [7:0] s_byte_1,
    input  logic [7:0] s_byte_2,
    input  logic [7:0] s_byte_3,
    input  logic [7:0] s_byte_4,
    input  logic [7:0] s_byte_5,
    input  logic [7:0] s_byte_6,
    input  logic [7:0] s_byte_7,
    input  logic       q_full,
    output logic       q_push,
    output entry_t     q_data
);

    logic [KEY_SLOTS-1:0][7:0] held_keys_reg, held_keys_next;
    logic [3:0]                held_mods_reg, held_mods_next;
    logic [2:0]                held_btn_reg, held_btn_next;

    logic [SLOT_MAX-1:0][7:0]  rep_keys;
    logic [SLOT_MAX-1:0][7:0]  old_keys;
    logic [SLOT_MAX-1:0]       rel_mask;
    logic [SLOT_MAX-1:0]       prs_mask;
    logic [3:0]                mod_mask;
    logic [3:0]                mods;
    logic [3:0]                mchg;
    logic [2:0]                btn;
    logic [2:0]                bchg;
    logic [2:0]                ax_mask;
    logic                      short_mouse;
    logic                      is_kbd;
    logic                      is_mouse;
    logic                      has_wheel;
    logic                      accept;
    logic                      rel_hit;
    logic                      prs_hit;

    assign rep_keys = {s_byte_7, s_byte_6, s_byte_5, s_byte_4, s_byte_3, s_byte_2};

    assign short_mouse = (s_report_len == LEN_MOUSE_SHORT) || (s_report_len == LEN_MOUSE);
    assign is_kbd      = s_report_len[3] && (s_byte_1 == 8'd0);
    assign is_mouse    = short_mouse || (s_report_len[3] && (s_byte_1 != 8'd0));
    assign has_wheel   = (s_report_len != LEN_MOUSE_SHORT);

    assign mods = s_byte_0[3:0];
    assign mchg = mods ^ held_mods_reg;
    assign btn  = s_byte_0[2:0];
    assign bchg = btn ^ held_btn_reg;

    assign ax_mask = {has_wheel && (s_byte_3 != 8'd0), s_byte_2 != 8'd0, s_byte_1 != 8'd0};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            mod_mask[i] = mchg[mod_map(i[1:0])];
        end
    end

    // release and press filtering against the previous and current key lists
    always_comb begin
        rel_mask = '0;
        prs_mask = '0;
        old_keys = '0;
        rel_hit  = 1'b0;
        prs_hit  = 1'b0;
        for (int i = 0; i < KEY_SLOTS; i++) begin
            old_keys[i] = held_keys_reg[i];
            rel_hit = 1'b0;
            prs_hit = 1'b0;
            for (int j = 0; j < KEY_SLOTS; j++) begin
                if (j < i && held_keys_reg[j] == held_keys_reg[i]) begin
                    rel_hit = 1'b1;
                end
                if (rep_keys[j] == held_keys_reg[i]) begin
                    rel_hit = 1'b1;
                end
                if (j < i && rep_keys[j] == rep_keys[i]) begin
                    prs_hit = 1'b1;
                end
                if (held_keys_reg[j] == rep_keys[i]) begin
                    prs_hit = 1'b1;
                end
            end
            rel_mask[i] = (held_keys_reg[i] != 8'd0) && !rel_hit &&
                          usage_mapped(held_keys_reg[i]);
            prs_mask[i] = (rep_keys[i] != 8'd0) && !prs_hit && usage_mapped(rep_keys[i]);
        end
    end

    always_comb begin
        q_data.is_kbd   = is_kbd;
        q_data.old_keys = old_keys;
        if (is_kbd) begin
            q_data.mask     = {prs_mask, rel_mask, mod_mask};
            q_data.bits     = mods;
            q_data.new_keys = rep_keys;
        end else begin
            q_data.mask     = {10'd0, ax_mask, bchg};
            q_data.bits     = {1'b0, btn};
            q_data.new_keys = {24'd0, s_byte_3, s_byte_2, s_byte_1};
        end
    end

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && (is_kbd || is_mouse) && (q_data.mask != '0);

    always_comb begin
        held_keys_next = held_keys_reg;
        held_mods_next = held_mods_reg;
        held_btn_next  = held_btn_reg;
        if (accept && is_kbd) begin
            held_mods_next = mods;
            for (int i = 0; i < KEY_SLOTS; i++) begin
                held_keys_next[i] = rep_keys[i];
            end
        end
        if (accept && is_mouse) begin
            held_btn_next = btn;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_keys_reg <= '0;
            held_mods_reg <= '0;
            held_btn_reg  <= '0;
        end else begin
            held_keys_reg <= held_keys_next;
            held_mods_reg <= held_mods_next;
            held_btn_reg  <= held_btn_next;
        end
    end

endmodule

/* hdl/hbred_queue.sv */
// ----------------------------------------------------------------------------
// hbred_queue
// Two-entry queue of classified reports between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbred_queue import hbred_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  entry_t din,
    input  logic   pop,
    output entry_t dout,
    output qstat_t stat
);

    entry_t     mem [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign stat.full  = (count_reg == 2'd2);
    assign stat.empty = (count_reg == 2'd0);
    assign dout       = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = !wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = !rd_ptr_reg;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* hdl/hbred_back.sv */
// ----------------------------------------------------------------------------
// hbred_back
// Walks the pending event mask and emits one event per cycle while the receiver does not hold the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbred_back import hbred_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_empty,
    input  entry_t            q_data,
    output logic              q_pop,
    output logic              work_busy,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_event_class,
    output logic [7:0]        m_code,
    output logic signed [7:0] m_value,
    output logic              m_last_event
);

    entry_t            work_reg, work_next;
    logic              work_valid_reg, work_valid_next;
    logic              m_valid_reg, m_valid_next;
    ev_class_t         class_reg, class_next;
    logic [7:0]        code_reg, code_next;
    logic signed [7:0] value_reg, value_next;
    logic              last_reg, last_next;

    logic [EV_IDX_W-1:0] sel;
    logic [EV_IDX_W-1:0] k;
    logic [EV_COUNT-1:0] low_bit;
    logic [EV_COUNT-1:0] rest;
    logic [1:0]          mb;
    logic                emit;
    logic                done;
    logic                load;

    always_comb begin
        sel = '0;
        for (int i = EV_COUNT - 1; i >= 0; i--) begin
            if (work_reg.mask[i]) begin
                sel = i[EV_IDX_W-1:0];
            end
        end
    end

    assign low_bit = work_reg.mask & (~work_reg.mask + 1'b1);
    assign rest    = work_reg.mask & ~low_bit;
    assign done    = (rest == '0);
    assign emit    = work_valid_reg && (!m_valid_reg || m_ready);
    assign load    = !q_empty && (!work_valid_reg || (emit && done));
    assign q_pop   = load;

    // event decode
    always_comb begin
        k  = '0;
        mb = mod_map(sel[1:0]);
        class_next = CLS_KEY;
        code_next  = 8'd0;
        value_next = 8'sd0;
        if (work_reg.is_kbd) begin
            if (sel < EV_REL_BASE) begin
                class_next = CLS_MOD;
                code_next  = {6'd0, mb};
                value_next = {7'd0, work_reg.bits[mb]};
            end else if (sel < EV_PRS_BASE) begin
                k          = sel - EV_REL_BASE;
                class_next = CLS_KEY;
                code_next  = work_reg.old_keys[k[2:0]];
                value_next = 8'sd0;
            end else begin
                k          = sel - EV_PRS_BASE;
                class_next = CLS_KEY;
                code_next  = work_reg.new_keys[k[2:0]];
                value_next = 8'sd1;
            end
        end else begin
            if (sel < EV_AXIS_BASE) begin
                class_next = CLS_BUTTON;
                code_next  = {6'd0, sel[1:0]};
                value_next = {7'd0, work_reg.bits[sel[1:0]]};
            end else begin
                k          = sel - EV_AXIS_BASE;
                class_next = CLS_AXIS;
                code_next  = {6'd0, k[1:0]};
                value_next = work_reg.new_keys[k[2:0]];
            end
        end
        last_next = done;
    end

    always_comb begin
        work_next       = work_reg;
        work_valid_next = work_valid_reg;
        if (emit) begin
            work_next.mask  = rest;
            work_valid_next = !done;
        end
        if (load) begin
            work_next       = q_data;
            work_valid_next = 1'b1;
        end
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            work_valid_reg <= work_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        if (emit) begin
            class_reg <= class_next;
            code_reg  <= code_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

    assign work_busy     = work_valid_reg;
    assign m_valid       = m_valid_reg;
    assign m_event_class = class_reg;
    assign m_code        = code_reg;
    assign m_value       = value_reg;
    assign m_last_event  = last_reg;

endmodule

/* hdl/hid_boot_report_event_decoder_unit.sv */
// ----------------------------------------------------------------------------
// hid_boot_report_event_decoder_unit
// The first event of a report passes the queue, the work register and the output register.
// Throughput: one event per cycle while m_ready does not hold the output; a report
// yields at most 16 events, and the back end has a single event emitter.
// A report is taken each cycle while the two-entry queue has room.
// Reset (aresetn low, synchronous) clears held keys, modifiers and buttons.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_boot_report_event_decoder_unit import hbred_pkg::*; #(
    parameter int KEY_SLOTS = 6
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [3:0]        s_report_len,
    input  logic [7:0]        s_byte_0,
    input  logic [7:0]        s_byte_1,
    input  logic [7:0]        s_byte_2,
    input  logic [7:0]        s_byte_3,
    input  logic [7:0]        s_byte_4,
    input  logic [7:0]        s_byte_5,
    input  logic [7:0]        s_byte_6,
    input  logic [7:0]        s_byte_7,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_event_class,
    output logic [7:0]        m_code,
    output logic signed [7:0] m_value,
    output logic              m_last_event
);

    entry_t q_in;
    entry_t q_out;
    qstat_t q_stat;
    logic   q_push;
    logic   q_pop;
    logic   back_busy;

    hbred_front #(
        .KEY_SLOTS(KEY_SLOTS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_report_len(s_report_len),
        .s_byte_0    (s_byte_0),
        .s_byte_1    (s_byte_1),
        .s_byte_2    (s_byte_2),
        .s_byte_3    (s_byte_3),
        .s_byte_4    (s_byte_4),
        .s_byte_5    (s_byte_5),
        .s_byte_6    (s_byte_6),
        .s_byte_7    (s_byte_7),
        .q_full      (q_stat.full),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    hbred_queue u_queue (
        .aclk   (aclk),
        .aresetn(aresetn),
        .push   (q_push),
        .din    (q_in),
        .pop    (q_pop),
        .dout   (q_out),
        .stat   (q_stat)
    );

    hbred_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_empty      (q_stat.empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .work_busy    (back_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_class(m_event_class),
        .m_code       (m_code),
        .m_value      (m_value),
        .m_last_event (m_last_event)
    );

`ifndef SYNTHESIS
    a_more_events: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_event) |=> m_valid)
        else $error("event stream broke before last event");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !back_busy) |=> !m_valid)
        else $error("event produced with no work pending");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("report pushed into full queue");

    a_pop_data: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");
`endif

endmodule

/* sim/hid_boot_report_event_decoder_unit_tb.sv */
// ----------------------------------------------------------------------------
// hid_boot_report_event_decoder_unit_tb
// Drives boot reports into the decoder and checks every event against a
// behavioral decoder kept in the bench. A short directed table covers
// ignored lengths, extremes, duplicate and unmapped usages and the long mouse
// form. A random run of keyboard-style report sequences, mouse reports and
// noise follows. Both channels idle at random. One long receiver hold-off
// backs the block up until it stalls its input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hid_boot_report_event_decoder_unit_tb import hbred_pkg::*;;

    localparam int KEY_SLOTS      = 6;
    localparam int RANDOM_REPORTS = 480;
    localparam int IDLE_PCT       = 38;
    localparam int CALM_FROM      = 200;
    localparam int CALM_TO        = 300;
    localparam int PRESSURE_AT    = 150;
    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    localparam logic [3:0] LEN_KBD = 4'd8;

    localparam logic [1:0] MOD_CTRL   = 2'd0;
    localparam logic [1:0] MOD_SHIFT  = 2'd1;
    localparam logic [1:0] MOD_ALT    = 2'd2;
    localparam logic [1:0] MOD_META   = 2'd3;
    localparam logic [1:0] BUTTON_L   = 2'd0;
    localparam logic [1:0] BUTTON_R   = 2'd1;
    localparam logic [1:0] BUTTON_M   = 2'd2;
    localparam logic [1:0] AXIS_X     = 2'd0;
    localparam logic [1:0] AXIS_Y     = 2'd1;
    localparam logic [1:0] AXIS_WHEEL = 2'd2;

    // emit order; code equals bit index
    localparam logic [0:3][1:0] MOD_ORDER  = {MOD_SHIFT, MOD_CTRL, MOD_ALT, MOD_META};
    localparam logic [0:2][1:0] BTN_ORDER  = {BUTTON_L, BUTTON_R, BUTTON_M};
    localparam logic [0:2][1:0] AXIS_ORDER = {AXIS_X, AXIS_Y, AXIS_WHEEL};

    localparam logic signed [7:0] RELEASE_VAL = 8'sd0;
    localparam logic signed [7:0] PRESS_VAL   = 8'sd1;

    typedef struct packed {
        ev_class_t         cls;
        logic [7:0]        code;
        logic signed [7:0] val;
        logic              last;
    } hid_event_t;

    typedef struct packed {
        logic [3:0]      len;
        logic [0:7][7:0] bytes;
    } boot_report_t;

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [3:0]        s_report_len = '0;
    logic [7:0]        s_byte_0     = '0;
    logic [7:0]        s_byte_1     = '0;
    logic [7:0]        s_byte_2     = '0;
    logic [7:0]        s_byte_3     = '0;
    logic [7:0]        s_byte_4     = '0;
    logic [7:0]        s_byte_5     = '0;
    logic [7:0]        s_byte_6     = '0;
    logic [7:0]        s_byte_7     = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [1:0]        m_event_class;
    logic [7:0]        m_code;
    logic signed [7:0] m_value;
    logic              m_last_event;

    // decoder state as the bench sees it
    logic [7:0] held_keys [KEY_SLOTS] = '{default: 8'h00};
    logic [3:0] held_mods = '0;
    logic [2:0] held_btns = '0;

    hid_event_t   decoded_events[$];
    hid_event_t   pending_events[$];
    hid_event_t   typed_events[$];
    boot_report_t table_reports[$];
    int           table_typed[$];
    hid_event_t   oldest_event;

    int reports_taken  = 0;
    int error_count    = 0;
    int hold_left      = 0;
    int stalled_cycles = 0;
    bit hold_done      = 1'b0;
    bit no_idle        = 1'b0;

    hid_boot_report_event_decoder_unit #(
        .KEY_SLOTS(KEY_SLOTS)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_report_len  (s_report_len),
        .s_byte_0      (s_byte_0),
        .s_byte_1      (s_byte_1),
        .s_byte_2      (s_byte_2),
        .s_byte_3      (s_byte_3),
        .s_byte_4      (s_byte_4),
        .s_byte_5      (s_byte_5),
        .s_byte_6      (s_byte_6),
        .s_byte_7      (s_byte_7),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_event_class (m_event_class),
        .m_code        (m_code),
        .m_value       (m_value),
        .m_last_event  (m_last_event)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic hid_event_t make_event(input ev_class_t cls, input logic [7:0] code,
                                              input logic signed [7:0] val, input logic last);
        hid_event_t e;
        e.cls  = cls;
        e.code = code;
        e.val  = val;
        e.last = last;
        return e;
    endfunction

    function automatic bit key_mapped(input logic [7:0] u);
        return ((u >= USAGE_A_LO) && (u <= USAGE_A_HI)) ||
               ((u >= USAGE_B_LO) && (u <= USAGE_B_HI));
    endfunction

    // events one report causes, with the held state moved on
    task automatic decode_boot_report(input boot_report_t r);
        logic [7:0] keys [KEY_SLOTS];
        logic [7:0] moves [3];
        logic [3:0] mods;
        logic [2:0] btns;
        logic [7:0] u;
        hid_event_t e;
        bit         skip;
        int         i, j;
        decoded_events.delete();
        if ((r.len == LEN_MOUSE_SHORT) || (r.len == LEN_MOUSE) ||
            ((r.len >= LEN_KBD) && (r.bytes[1] != 8'h00))) begin
            btns = r.bytes[0][2:0];
            for (i = 0; i < 3; i++) begin
                if (btns[BTN_ORDER[i]] != held_btns[BTN_ORDER[i]]) begin
                    decoded_events.push_back(make_event(CLS_BUTTON, {6'd0, BTN_ORDER[i]},
                        btns[BTN_ORDER[i]] ? PRESS_VAL : RELEASE_VAL, 1'b0));
                end
            end
            held_btns = btns;
            moves[AXIS_X]     = r.bytes[1];
            moves[AXIS_Y]     = r.bytes[2];
            moves[AXIS_WHEEL] = (r.len == LEN_MOUSE_SHORT) ? 8'h00 : r.bytes[3];
            for (i = 0; i < 3; i++) begin
                if (moves[AXIS_ORDER[i]] != 8'h00) begin
                    decoded_events.push_back(make_event(CLS_AXIS, {6'd0, AXIS_ORDER[i]},
                        moves[AXIS_ORDER[i]], 1'b0));
                end
            end
        end else if (r.len >= LEN_KBD) begin
            mods = r.bytes[0][3:0];
            for (i = 0; i < 4; i++) begin
                if (mods[MOD_ORDER[i]] != held_mods[MOD_ORDER[i]]) begin
                    decoded_events.push_back(make_event(CLS_MOD, {6'd0, MOD_ORDER[i]},
                        mods[MOD_ORDER[i]] ? PRESS_VAL : RELEASE_VAL, 1'b0));
                end
            end
            held_mods = mods;
            for (i = 0; i < KEY_SLOTS; i++) begin
                keys[i] = r.bytes[2 + i];
            end
            // releases: held usages gone from the report, first copy only
            for (i = 0; i < KEY_SLOTS; i++) begin
                u    = held_keys[i];
                skip = (u == 8'h00) || !key_mapped(u);
                for (j = 0; j < i; j++) begin
                    if (held_keys[j] == u) skip = 1'b1;
                end
                for (j = 0; j < KEY_SLOTS; j++) begin
                    if (keys[j] == u) skip = 1'b1;
                end
                if (!skip) decoded_events.push_back(make_event(CLS_KEY, u, RELEASE_VAL, 1'b0));
            end
            // presses: new usages not held before
            for (i = 0; i < KEY_SLOTS; i++) begin
                u    = keys[i];
                skip = (u == 8'h00) || !key_mapped(u);
                for (j = 0; j < i; j++) begin
                    if (keys[j] == u) skip = 1'b1;
                end
                for (j = 0; j < KEY_SLOTS; j++) begin
                    if (held_keys[j] == u) skip = 1'b1;
                end
                if (!skip) decoded_events.push_back(make_event(CLS_KEY, u, PRESS_VAL, 1'b0));
            end
            for (i = 0; i < KEY_SLOTS; i++) begin
                held_keys[i] = keys[i];
            end
        end
        if (decoded_events.size() != 0) begin
            e      = decoded_events.pop_back();
            e.last = 1'b1;
            decoded_events.push_back(e);
        end
    endtask

    task automatic add_report(input logic [3:0] len, input logic [0:7][7:0] bytes,
                              input int n_typed);
        boot_report_t r;
        r.len   = len;
        r.bytes = bytes;
        table_reports.push_back(r);
        table_typed.push_back(n_typed);
    endtask

    // offer one report, then book the events it must cause
    task automatic take_report(input boot_report_t r, input int n_typed);
        int k;
        while (!no_idle && ($urandom_range(99) < IDLE_PCT)) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_report_len <= r.len;
        s_byte_0     <= r.bytes[0];
        s_byte_1     <= r.bytes[1];
        s_byte_2     <= r.bytes[2];
        s_byte_3     <= r.bytes[3];
        s_byte_4     <= r.bytes[4];
        s_byte_5     <= r.bytes[5];
        s_byte_6     <= r.bytes[6];
        s_byte_7     <= r.bytes[7];
        do @(posedge aclk); while (s_ready !== 1'b1);
        reports_taken++;
        decode_boot_report(r);
        if (n_typed < 0) begin
            for (k = 0; k < decoded_events.size(); k++) begin
                pending_events.push_back(decoded_events[k]);
            end
        end else begin
            repeat (n_typed) pending_events.push_back(typed_events.pop_front());
        end
    endtask

    task automatic random_report(output boot_report_t r);
        int pick, i;
        r.bytes = {$urandom, $urandom};
        pick    = $urandom_range(99);
        if (pick < 55) begin
            // keyboard sequence that partly evolves from the held keys
            r.len = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9)) : LEN_KBD;
            if ($urandom_range(1) == 1) r.bytes[0][3:0] = held_mods;
            r.bytes[1] = 8'h00;
            for (i = 0; i < KEY_SLOTS; i++) begin
                pick = $urandom_range(99);
                if (pick < 35) begin
                    r.bytes[2 + i] = held_keys[$urandom_range(KEY_SLOTS - 1)];
                end else if (pick < 55) begin
                    r.bytes[2 + i] = 8'h00;
                end else if (pick < 70) begin
                    r.bytes[2 + i] = 8'($urandom_range(USAGE_B_HI, USAGE_B_LO));
                end else if (pick < 92) begin
                    r.bytes[2 + i] = 8'($urandom_range(USAGE_A_HI, USAGE_A_LO));
                end
            end
        end else if (pick < 85) begin
            case ($urandom_range(2))
                0: r.len = LEN_MOUSE_SHORT;
                1: r.len = LEN_MOUSE;
                default: r.len = 4'($urandom_range(15, 8));
            endcase
            if ($urandom_range(1) == 1) r.bytes[0][2:0] = held_btns;
            for (i = 1; i < 4; i++) begin
                if ($urandom_range(2) == 0) r.bytes[i] = 8'h00;
            end
            if ((r.len >= LEN_KBD) && (r.bytes[1] == 8'h00)) begin
                r.bytes[1] = 8'($urandom_range(255, 1));
            end
        end else begin
            // noise: any length, raw bytes
            r.len = 4'($urandom_range(15));
        end
    endtask

    task automatic report_field(input string name, input int want, input int got);
        $display("%0t ns: %s mismatch, expected %0d actual %0d", $time, name, want, got);
        error_count++;
    endtask

    // result side: check each transfer, then pick the next ready level
    always @(posedge aclk) begin
        if ((m_valid === 1'b1) && m_ready) begin
            if (pending_events.size() == 0) begin
                $display("%0t ns: event with none expected, class %0d code %0d value %0d last %0b",
                         $time, m_event_class, m_code, m_value, m_last_event);
                error_count++;
            end else begin
                oldest_event = pending_events.pop_front();
                if (m_event_class !== oldest_event.cls) begin
                    report_field("event_class", oldest_event.cls, m_event_class);
                end
                if (m_code !== oldest_event.code) begin
                    report_field("code", oldest_event.code, m_code);
                end
                if (m_value !== oldest_event.val) begin
                    report_field("value", oldest_event.val, m_value);
                end
                if (m_last_event !== oldest_event.last) begin
                    report_field("last_event", oldest_event.last, m_last_event);
                end
            end
        end
        if (!hold_done && (reports_taken >= PRESSURE_AT)) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    initial begin
        while (stalled_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && (s_ready === 1'b1)) || ((m_valid === 1'b1) && m_ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
        end
        $display("%0t ns: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        boot_report_t r;
        int           row;
        int           counted;

        // ignored lengths change nothing
        add_report(4'd0, 64'hFFFF_FFFF_FFFF_FFFF, 0);
        add_report(4'd1, 64'h0000_0000_0000_0000, 0);
        add_report(4'd2, 64'h0700_0404_0404_0404, 0);
        add_report(4'd5, 64'hFF00_1122_3344_5566, 0);
        add_report(4'd6, 64'h0F00_0405_0607_0809, 0);
        add_report(4'd7, 64'h0200_0400_0000_0000, 0);
        // first keyboard report after reset
        add_report(LEN_KBD, 64'h0200_0400_0000_0000, 2);
        typed_events.push_back(make_event(CLS_MOD, {6'd0, MOD_SHIFT}, PRESS_VAL, 1'b0));
        typed_events.push_back(make_event(CLS_KEY, 8'h04, PRESS_VAL, 1'b1));
        // mouse extremes after reset
        add_report(LEN_MOUSE, 64'hFF80_7FFF_0000_0000, 6);
        typed_events.push_back(make_event(CLS_BUTTON, {6'd0, BUTTON_L}, PRESS_VAL, 1'b0));
        typed_events.push_back(make_event(CLS_BUTTON, {6'd0, BUTTON_R}, PRESS_VAL, 1'b0));
        typed_events.push_back(make_event(CLS_BUTTON, {6'd0, BUTTON_M}, PRESS_VAL, 1'b0));
        typed_events.push_back(make_event(CLS_AXIS, {6'd0, AXIS_X}, 8'sh80, 1'b0));
        typed_events.push_back(make_event(CLS_AXIS, {6'd0, AXIS_Y}, 8'sh7F, 1'b0));
        typed_events.push_back(make_event(CLS_AXIS, {6'd0, AXIS_WHEEL}, 8'shFF, 1'b1));
        // three byte mouse, long mouse, long keyboard with duplicates, unmapped usages
        add_report(LEN_MOUSE_SHORT, 64'h0001_FF55_AAAA_AAAA, -1);
        add_report(4'd15, 64'h057F_0080_0000_0000, -1);
        add_report(4'd9, 64'h0F00_0404_2E4F_5205, -1);
        add_report(LEN_KBD, 64'hF000_0103_2F4E_53FF, -1);
        add_report(LEN_KBD, 64'h0000_0000_0000_0000, -1);
        // full swap of six keys with all modifiers: sixteen events
        add_report(LEN_KBD, 64'h0000_0405_0607_0809, -1);
        add_report(LEN_KBD, 64'h0F00_0A0B_0C0D_0E0F, -1);
        add_report(LEN_MOUSE, 64'hFD00_0000_0000_0000, -1);
        add_report(4'd15, 64'hFFFF_FFFF_FFFF_FFFF, -1);
        add_report(LEN_KBD, 64'h0000_0000_0000_0000, -1);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (row = 0; row < table_reports.size(); row++) begin
            take_report(table_reports[row], table_typed[row]);
        end

        counted = 0;
        while (counted < RANDOM_REPORTS) begin
            no_idle = (counted >= CALM_FROM) && (counted < CALM_TO);
            random_report(r);
            take_report(r, -1);
            if ((r.len == LEN_MOUSE_SHORT) || (r.len == LEN_MOUSE) || (r.len >= LEN_KBD)) begin
                counted++;
            end
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
